@@ rtl/cfi_pkg.sv @@
// Shared types and constants for the color fade interpolator.
`timescale 1ns / 1ps
`default_nettype none
package cfi_pkg;

   localparam int NUM_LANES   = 4;
   localparam int COLOR_W     = 8;
   localparam int STEP_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int MIX_W       = COLOR_W + STEP_W;
   localparam int PROD_W      = MIX_W + GAIN_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CNT_W       = 4;

   // One step per bit of the color, of the gain and of the quotient.
   localparam logic [CNT_W-1:0] MIX_LAST = CNT_W'(COLOR_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STEP_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RED   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_GREEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BLUE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_STEPS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_GAIN   = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } cfi_state_type;

   typedef struct packed {
      logic load;
      logic mix_en;
      logic mul_en;
      logic prep_en;
      logic div_en;
   } cfi_ctl_type;

endpackage
`default_nettype wire

@@ rtl/cfi_if.sv @@
// Handshake interfaces for the request, response and register write channels.
`timescale 1ns / 1ps
`default_nettype none
interface cfi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] now_red;
   logic [7:0] now_green;
   logic [7:0] now_blue;
   logic [7:0] now_alpha;
   modport source (output valid, now_red, now_green, now_blue, now_alpha, input ready);
   modport sink   (input valid, now_red, now_green, now_blue, now_alpha, output ready);
endinterface

interface cfi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       done_res;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, done_res,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, done_res,
                   output ready);
endinterface

interface cfi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/cfi_lane.sv @@
// One color channel: bit-serial blend, gain multiply and restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module cfi_lane (
   input  wire logic                        clock,
   input  wire cfi_pkg::cfi_ctl_type        ctl,
   input  wire logic                        latch,
   input  wire logic [cfi_pkg::COLOR_W-1:0] now_col,
   input  wire logic [cfi_pkg::COLOR_W-1:0] target,
   input  wire logic [cfi_pkg::STEP_W-1:0]  remain,
   input  wire logic [cfi_pkg::STEP_W-1:0]  step,
   input  wire logic [cfi_pkg::STEP_W-1:0]  steps,
   input  wire logic                        gain_bit,
   output logic      [cfi_pkg::COLOR_W-1:0] result
);
   import cfi_pkg::*;

   logic [COLOR_W-1:0] start_ff;
   logic [COLOR_W-1:0] sa_ff, sb_ff;
   logic [MIX_W-1:0]   mix_ff, mix_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [STEP_W-1:0]  rem_ff, quo_ff;
   logic [PROD_W:0]    biased;
   logic [STEP_W:0]    rem_wide, rem_diff;
   logic               take;

   // MSB-first shift-and-add: start*(N-s) + target*s
   assign mix_in = {mix_ff[MIX_W-2:0], 1'b0}
                 + (sa_ff[COLOR_W-1] ? MIX_W'(remain) : '0)
                 + (sb_ff[COLOR_W-1] ? MIX_W'(step) : '0);

   assign prod_in = {prod_ff[PROD_W-2:0], 1'b0} + (gain_bit ? PROD_W'(mix_ff) : '0);

   // round half up: add 128*N, then drop the low byte
   assign biased = {1'b0, prod_ff} + (PROD_W+1)'({steps, 7'b0});

   assign rem_wide = {rem_ff, quo_ff[STEP_W-1]};
   assign rem_diff = rem_wide - {1'b0, steps};
   assign take     = (rem_wide >= {1'b0, steps});

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         if (latch) begin
            start_ff <= now_col;
         end
         sa_ff   <= latch ? now_col : start_ff;
         sb_ff   <= target;
         mix_ff  <= '0;
         prod_ff <= '0;
      end else if (ctl.mix_en) begin
         mix_ff <= mix_in;
         sa_ff  <= {sa_ff[COLOR_W-2:0], 1'b0};
         sb_ff  <= {sb_ff[COLOR_W-2:0], 1'b0};
      end else if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end else if (ctl.prep_en) begin
         // quotient fits 16 bits, so the upper half is already below N
         rem_ff <= biased[PROD_W-1:PROD_W-STEP_W];
         quo_ff <= biased[PROD_W-STEP_W-1:8];
      end else if (ctl.div_en) begin
         rem_ff <= take ? rem_diff[STEP_W-1:0] : rem_wide[STEP_W-1:0];
         quo_ff <= {quo_ff[STEP_W-2:0], take};
      end
   end

   assign result = quo_ff[COLOR_W-1:0];

endmodule
`default_nettype wire

@@ rtl/cfi_ctrl.sv @@
// Sequencer that walks the lanes through blend, multiply and divide.
`timescale 1ns / 1ps
`default_nettype none
module cfi_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_fire,
   input  wire logic                 fade,
   input  wire logic                 out_free,
   output logic                      req_ready,
   output logic                      out_load,
   output cfi_pkg::cfi_ctl_type      ctl
);
   import cfi_pkg::*;

   cfi_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff + 1'b1;
      req_ready = 1'b0;
      out_load  = 1'b0;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_fire) begin
               ctl.load = 1'b1;
               state_in = fade ? ST_MIX : ST_FINISH;
            end
         end
         ST_MIX: begin
            ctl.mix_en = 1'b1;
            if (cnt_ff == MIX_LAST) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.mul_en = 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            ctl.prep_en = 1'b1;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            ctl.div_en = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cnt_in = '0;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/color_fade_interpolator.sv @@
// Top level: linear RGBA fade with Q8.8 gain, four bit-serial lanes.
// During a fade a request beat runs through 8 blend, 16 multiply, 1 round and 16 divide
// steps, then the finish state loads the response register; once the fade is done it goes
// straight to the finish state. A new request is taken only in idle, after the response
// register has been loaded, and the finish state stalls while a held response is not yet taken.
// Reset clears step count, configuration registers (gain to unity) and response valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module color_fade_interpolator (
   input  wire logic clock,
   input  wire logic reset,
   cfi_req_if.sink   req_bus,
   cfi_rsp_if.source rsp_bus,
   cfi_csr_if.sink   csr_bus
);
   import cfi_pkg::*;

   logic [COLOR_W-1:0] target_ff [NUM_LANES];
   logic [STEP_W-1:0]  steps_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  s_ff, ns_ff;
   logic [GAIN_W-1:0]  gsh_ff;
   logic               fade_ff;

   logic               out_valid_ff;
   logic [COLOR_W-1:0] out_col_ff [NUM_LANES];
   logic               done_ff;

   logic [COLOR_W-1:0] now_col [NUM_LANES];
   logic [COLOR_W-1:0] lane_res [NUM_LANES];
   logic               req_ready, req_fire, csr_fire, csr_hit;
   logic               fade, out_free, out_load, latch;
   cfi_ctl_type        ctl;

   assign now_col[0] = req_bus.now_red;
   assign now_col[1] = req_bus.now_green;
   assign now_col[2] = req_bus.now_blue;
   assign now_col[3] = req_bus.now_alpha;

   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;
   assign csr_hit       = csr_fire && (csr_bus.index inside {[CSR_TARGET_RED:CSR_LEVEL_GAIN]});
   assign fade          = (step_ff < steps_ff);
   assign latch         = (step_ff == '0);
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   cfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .fade      (fade),
      .out_free  (out_free),
      .req_ready (req_ready),
      .out_load  (out_load),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      cfi_lane u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .latch    (latch),
         .now_col  (now_col[i]),
         .target   (target_ff[i]),
         .remain   (ns_ff),
         .step     (s_ff),
         .steps    (steps_ff),
         .gain_bit (gsh_ff[GAIN_W-1]),
         .result   (lane_res[i])
      );
   end

   // configuration registers and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            target_ff[i] <= '0;
         end
         steps_ff <= '0;
         gain_ff  <= GAIN_UNITY;
         step_ff  <= '0;
      end else begin
         if (csr_fire) begin
            case (csr_bus.index)
               CSR_TARGET_RED:   target_ff[0] <= csr_bus.wdata[COLOR_W-1:0];
               CSR_TARGET_GREEN: target_ff[1] <= csr_bus.wdata[COLOR_W-1:0];
               CSR_TARGET_BLUE:  target_ff[2] <= csr_bus.wdata[COLOR_W-1:0];
               CSR_TARGET_ALPHA: target_ff[3] <= csr_bus.wdata[COLOR_W-1:0];
               CSR_FADE_STEPS:   steps_ff     <= csr_bus.wdata[STEP_W-1:0];
               CSR_LEVEL_GAIN:   gain_ff      <= csr_bus.wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (csr_hit) begin
            step_ff <= '0;
         end else if (req_fire && fade) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // per-beat operands, held while the lanes work; the gain copy shifts during the multiply
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s_ff    <= step_ff;
         ns_ff   <= steps_ff - step_ff;
         gsh_ff  <= gain_ff;
         fade_ff <= fade;
      end else if (ctl.mul_en) begin
         gsh_ff <= {gsh_ff[GAIN_W-2:0], 1'b0};
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            out_col_ff[i] <= fade_ff ? lane_res[i] : target_ff[i];
         end
         done_ff <= !fade_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.out_red   = out_col_ff[0];
   assign rsp_bus.out_green = out_col_ff[1];
   assign rsp_bus.out_blue  = out_col_ff[2];
   assign rsp_bus.out_alpha = out_col_ff[3];
   assign rsp_bus.done_res  = done_ff;

endmodule
`default_nettype wire
